[design/debug_packet_deframer_assert.svh]
// Assertion macros for the debug packet deframer.
// Used by the top level through `include; no other dependencies.
`ifndef DEBUG_PACKET_DEFRAMER_ASSERT_SVH
`define DEBUG_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define DPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DPD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DPD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[design/dpd_pkg.sv]
// Package for the debug packet deframer: widths, character codes,
// phase and event codes, and the structs passed between modules.
package dpd_pkg;

   localparam int LengthLimit = 32767;
   localparam int CountW      = $clog2(LengthLimit + 1);
   localparam int PayloadLenW = 15;
   localparam int EventW      = 3;
   localparam int PhaseW      = 3;

   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChHash   = 8'h23;
   localparam logic [7:0] ChEscape = 8'h7D;
   localparam logic [7:0] ChPlus   = 8'h2B;
   localparam logic [7:0] ChMinus  = 8'h2D;
   localparam logic [7:0] EscXor   = 8'h20;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChLowA   = 8'h61;
   localparam logic [7:0] ChLowF   = 8'h66;

   localparam logic [PhaseW-1:0] PhIdle = 3'd0;
   localparam logic [PhaseW-1:0] PhBody = 3'd1;
   localparam logic [PhaseW-1:0] PhEsc  = 3'd2;
   localparam logic [PhaseW-1:0] PhHi   = 3'd3;
   localparam logic [PhaseW-1:0] PhLo   = 3'd4;

   localparam logic [EventW-1:0] EvData = 3'd0;
   localparam logic [EventW-1:0] EvGood = 3'd1;
   localparam logic [EventW-1:0] EvBad  = 3'd2;
   localparam logic [EventW-1:0] EvAck  = 3'd3;
   localparam logic [EventW-1:0] EvNack = 3'd4;
   localparam logic [EventW-1:0] EvLink = 3'd5;
   localparam logic [EventW-1:0] EvOver = 3'd6;

   localparam logic [CountW-1:0] CountLimit = CountW'(LengthLimit);

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [7:0]        sum;
      logic [CountW-1:0] count;
      logic [3:0]        high;
   } frame_state_type;

   typedef struct packed {
      logic                   valid;
      logic [EventW-1:0]      event_res;
      logic [7:0]             data_byte;
      logic [PayloadLenW-1:0] payload_length;
   } frame_result_type;

   // low bits of the byte count as shown on the result channel
   function automatic logic [PayloadLenW-1:0] shown_len(input logic [CountW-1:0] count);
      logic [31:0] wide;
      wide = 32'(count);
      return wide[PayloadLenW-1:0];
   endfunction

endpackage

[design/dpd_req_if.sv]
// Input channel of the debug packet deframer: one link byte per item.
// No other dependencies.
interface dpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       link_closed;

   modport source (output valid, output rx_byte, output link_closed, input ready);
   modport sink   (input valid, input rx_byte, input link_closed, output ready);
endinterface

[design/dpd_rsp_if.sv]
// Result channel of the debug packet deframer: one event per item.
// Depends on dpd_pkg.
interface dpd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dpd_pkg::EventW-1:0]      event_res;
   logic [7:0]                      data_byte;
   logic [dpd_pkg::PayloadLenW-1:0] payload_length;

   modport source (output valid, output event_res, output data_byte,
                   output payload_length, input ready);
   modport sink   (input valid, input event_res, input data_byte,
                   input payload_length, output ready);
endinterface

[design/dpd_step.sv]
// Per-byte framing logic: next frame state and optional result.
// Purely combinational; depends on dpd_pkg.
module dpd_step (
   input  dpd_pkg::frame_state_type  state_cur,
   input  logic [7:0]                rx_byte,
   input  logic                      link_closed,
   output dpd_pkg::frame_state_type  state_nxt,
   output dpd_pkg::frame_result_type result
);

   logic       is_dec;
   logic       is_hex;
   logic [3:0] digit;
   logic       at_limit;
   logic [7:0] sum_add;
   logic [7:0] data_dec;
   logic [dpd_pkg::CountW-1:0] count_inc;

   always_comb begin
      is_dec    = (rx_byte >= dpd_pkg::ChZero) && (rx_byte <= dpd_pkg::ChNine);
      is_hex    = is_dec || ((rx_byte >= dpd_pkg::ChLowA) && (rx_byte <= dpd_pkg::ChLowF));
      digit     = is_dec ? rx_byte[3:0] : rx_byte[3:0] + 4'd9;
      at_limit  = state_cur.count >= dpd_pkg::CountLimit;
      sum_add   = state_cur.sum + rx_byte;
      data_dec  = (state_cur.phase == dpd_pkg::PhEsc) ? (rx_byte ^ dpd_pkg::EscXor) : rx_byte;
      count_inc = state_cur.count + 1'b1;

      state_nxt             = state_cur;
      result.valid          = 1'b0;
      result.event_res      = dpd_pkg::EvData;
      result.data_byte      = 8'h00;
      result.payload_length = dpd_pkg::shown_len(state_cur.count);

      if ((state_cur.phase < dpd_pkg::PhBody) || (state_cur.phase > dpd_pkg::PhLo)) begin
         state_nxt.phase       = dpd_pkg::PhIdle;
         result.payload_length = '0;
         priority if (link_closed) begin
            result.valid     = 1'b1;
            result.event_res = dpd_pkg::EvLink;
         end else if (rx_byte == dpd_pkg::ChPlus) begin
            result.valid     = 1'b1;
            result.event_res = dpd_pkg::EvAck;
         end else if (rx_byte == dpd_pkg::ChMinus) begin
            result.valid     = 1'b1;
            result.event_res = dpd_pkg::EvNack;
         end else if (rx_byte == dpd_pkg::ChDollar) begin
            state_nxt.phase = dpd_pkg::PhBody;
            state_nxt.sum   = '0;
            state_nxt.count = '0;
            state_nxt.high  = '0;
         end else begin
            // any other byte between packets is dropped
         end
      end else if (link_closed) begin
         state_nxt.phase  = dpd_pkg::PhIdle;
         result.valid     = 1'b1;
         result.event_res = dpd_pkg::EvLink;
      end else if ((state_cur.phase == dpd_pkg::PhBody) && (rx_byte == dpd_pkg::ChHash)) begin
         state_nxt.phase = dpd_pkg::PhHi;
      end else if ((state_cur.phase == dpd_pkg::PhBody) && (rx_byte == dpd_pkg::ChEscape)) begin
         state_nxt.sum   = sum_add;
         state_nxt.phase = dpd_pkg::PhEsc;
      end else if ((state_cur.phase == dpd_pkg::PhBody) || (state_cur.phase == dpd_pkg::PhEsc)) begin
         // payload byte, plain or escaped
         state_nxt.sum = sum_add;
         result.valid  = 1'b1;
         if (at_limit) begin
            state_nxt.phase  = dpd_pkg::PhIdle;
            result.event_res = dpd_pkg::EvOver;
         end else begin
            state_nxt.phase       = dpd_pkg::PhBody;
            state_nxt.count       = count_inc;
            result.event_res      = dpd_pkg::EvData;
            result.data_byte      = data_dec;
            result.payload_length = dpd_pkg::shown_len(count_inc);
         end
      end else if (state_cur.phase == dpd_pkg::PhHi) begin
         if (is_hex) begin
            state_nxt.high  = digit;
            state_nxt.phase = dpd_pkg::PhLo;
         end else begin
            state_nxt.phase  = dpd_pkg::PhIdle;
            result.valid     = 1'b1;
            result.event_res = dpd_pkg::EvBad;
         end
      end else begin
         // low checksum digit closes the packet
         state_nxt.phase = dpd_pkg::PhIdle;
         result.valid    = 1'b1;
         priority if (!is_hex)
            result.event_res = dpd_pkg::EvBad;
         else if (at_limit)
            result.event_res = dpd_pkg::EvOver;
         else if ({state_cur.high, digit} == state_cur.sum)
            result.event_res = dpd_pkg::EvGood;
         else
            result.event_res = dpd_pkg::EvBad;
      end
   end

endmodule

[design/debug_packet_deframer.sv]
// Top level of the debug packet deframer: input register, frame state,
// result register. Depends on dpd_pkg, dpd_req_if, dpd_rsp_if, dpd_step.
//
//   port      dir   carries
//   req_chan  in    rx_byte, link_closed  (one link byte or end of stream)
//   rsp_chan  out   event_res, data_byte, payload_length
//
// One item per cycle sustained while results are taken; a result, if any, passes
// the input and result registers in turn. The only loop is the frame state
// register around dpd_step. Reset (synchronous) empties both registers and
// returns to idle. A stalled result holds the result register, which in turn
// holds the input register; req ready drops only when both are full.
`include "debug_packet_deframer_assert.svh"

module debug_packet_deframer (
   input logic       clock,
   input logic       reset,
   dpd_req_if.sink   req_chan,
   dpd_rsp_if.source rsp_chan
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_closed_ff;

   // frame state and result register
   dpd_pkg::frame_state_type  state_ff, state_in;
   dpd_pkg::frame_result_type step_res;
   logic                      rsp_valid_ff, rsp_valid_in;
   dpd_pkg::frame_result_type rsp_ff;

   logic advance;   // item in input register gets processed this cycle
   logic req_take;

   dpd_step u_step (
      .state_cur   (state_ff),
      .rx_byte     (in_byte_ff),
      .link_closed (in_closed_ff),
      .state_nxt   (state_in),
      .result      (step_res)
   );

   // the result slot is free if empty or being drained this cycle
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready)
         in_valid_in = req_chan.valid;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
      if (advance && step_res.valid)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff.phase  <= dpd_pkg::PhIdle;
         state_ff.sum    <= '0;
         state_ff.count  <= '0;
         state_ff.high   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance)
            state_ff <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff   <= req_chan.rx_byte;
         in_closed_ff <= req_chan.link_closed;
      end
      if (advance && step_res.valid)
         rsp_ff <= step_res;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.event_res      = rsp_ff.event_res;
   assign rsp_chan.data_byte      = rsp_ff.data_byte;
   assign rsp_chan.payload_length = rsp_ff.payload_length;

   // a waiting result is never overwritten
   `DPD_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_chan.ready, !advance || !step_res.valid, "result overwritten while stalled")
   // end of stream always drops back to idle
   `DPD_ASSERT_NXT(a_closed_idle, clock, reset, advance && in_closed_ff, state_ff.phase == dpd_pkg::PhIdle, "link closed did not return to idle")
   // only payload results carry a data byte
   `DPD_ASSERT_IMP(a_data_zero, clock, reset, rsp_valid_ff && (rsp_ff.event_res != dpd_pkg::EvData), rsp_ff.data_byte == 8'h00, "non-payload result carries data")
   // a payload byte always counts at least one
   `DPD_ASSERT_IMP(a_data_len, clock, reset, rsp_valid_ff && (rsp_ff.event_res == dpd_pkg::EvData), rsp_ff.payload_length != '0, "payload result with zero length")

endmodule
